FILE: hdl/leol_pkg.sv
package leol_pkg;

  // Byte codes
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] MASK_STRIP = 8'h7F;
  localparam logic [7:0] MASK_FULL  = 8'hFF;

  // Line ending translation codes; codes above MODE_LF_CR act as drop
  localparam logic [2:0] MODE_DROP  = 3'd0;
  localparam logic [2:0] MODE_CR    = 3'd1;
  localparam logic [2:0] MODE_LF    = 3'd2;
  localparam logic [2:0] MODE_CR_LF = 3'd3;
  localparam logic [2:0] MODE_LF_CR = 3'd4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_CR_TRANSLATION     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LF_TRANSLATION     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIP_HIGH_BIT     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPAND_BLANK_LINES = 8'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cr_translation;
    logic [2:0] lf_translation;
    logic       strip_high_bit;
    logic       expand_blank_lines;
  } cfg_t;

  // One decoded input: up to three bytes to emit, byte 0 first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: hdl/leol_front.sv
module leol_front import leol_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     accept,
  input  in_item_t item,
  output logic     push,
  output run_t     run
);

  logic [7:0] prev_out_byte, prev_out_byte_next;
  logic [7:0] prev_prev_out_byte, prev_prev_out_byte_next;
  logic [1:0] history_count, history_count_next;

  logic [7:0] p1, p2;
  logic [1:0] hcnt;
  logic       is_cr, is_lf, is_eol, match;
  logic [2:0] mode;
  logic [1:0] len;
  logic [7:0] s0, s1;
  logic [2:0] sum;

  // Block start clears history before the byte is handled
  always_comb begin
    p1   = item.block_start ? 8'd0 : prev_out_byte;
    p2   = item.block_start ? 8'd0 : prev_prev_out_byte;
    hcnt = item.block_start ? 2'd0 : history_count;
  end

  always_comb begin
    is_cr  = (item.in_byte == CHR_CR);
    is_lf  = (item.in_byte == CHR_LF);
    is_eol = is_cr || is_lf;
    mode   = is_cr ? cfg.cr_translation : cfg.lf_translation;
    len    = 2'd0;
    s0     = 8'd0;
    s1     = 8'd0;
    unique case (mode)
      MODE_CR: begin
        len = 2'd1;
        s0  = CHR_CR;
      end
      MODE_LF: begin
        len = 2'd1;
        s0  = CHR_LF;
      end
      MODE_CR_LF: begin
        len = 2'd2;
        s0  = CHR_CR;
        s1  = CHR_LF;
      end
      MODE_LF_CR: begin
        len = 2'd2;
        s0  = CHR_LF;
        s1  = CHR_CR;
      end
      default: len = 2'd0;
    endcase
  end

  always_comb begin
    match = 1'b0;
    if (cfg.expand_blank_lines && (len != 2'd0) && (hcnt >= len)) begin
      if (len == 2'd1) match = (p1 == s0);
      else             match = (p2 == s0) && (p1 == s1);
    end
  end

  always_comb begin
    run.bytes = '0;
    run.count = 2'd0;
    if (is_eol) begin
      if (match) begin
        run.bytes[0] = CHR_SPACE;
        run.bytes[1] = s0;
        run.bytes[2] = s1;
        run.count    = len + 2'd1;
      end else begin
        run.bytes[0] = s0;
        run.bytes[1] = s1;
        run.count    = len;
      end
    end else begin
      run.bytes[0] = item.in_byte & (cfg.strip_high_bit ? MASK_STRIP : MASK_FULL);
      run.count    = 2'd1;
    end
  end

  assign push = accept && (run.count != 2'd0);

  // Advance history by the bytes of this run
  always_comb begin
    prev_out_byte_next      = p1;
    prev_prev_out_byte_next = p2;
    unique case (run.count)
      2'd1: begin
        prev_prev_out_byte_next = p1;
        prev_out_byte_next      = run.bytes[0];
      end
      2'd2: begin
        prev_prev_out_byte_next = run.bytes[0];
        prev_out_byte_next      = run.bytes[1];
      end
      2'd3: begin
        prev_prev_out_byte_next = run.bytes[1];
        prev_out_byte_next      = run.bytes[2];
      end
      default: begin
        prev_out_byte_next      = p1;
        prev_prev_out_byte_next = p2;
      end
    endcase
    sum                = {1'b0, hcnt} + {1'b0, run.count};
    history_count_next = (sum >= 3'd2) ? 2'd2 : sum[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out_byte      <= 8'd0;
      prev_prev_out_byte <= 8'd0;
      history_count      <= 2'd0;
    end else if (accept) begin
      prev_out_byte      <= prev_out_byte_next;
      prev_prev_out_byte <= prev_prev_out_byte_next;
      history_count      <= history_count_next;
    end
  end

endmodule

FILE: hdl/leol_queue.sv
module leol_queue import leol_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  run_t          push_run,
  input  logic          pop,
  output run_t          head,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  run_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hdl/leol_back.sv
module leol_back import leol_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  run_t      head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [1:0] idx;
  logic       load, last;

  assign load = !out_valid || !out_stall;
  assign last = (idx == head.count - 2'd1);
  assign pop  = load && head_valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_data.out_byte    <= head.bytes[idx];
      out_data.last_of_run <= last;
    end
  end

endmodule

FILE: hdl/line_ending_translator_core.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_data   (in_item_t: in_byte, block_start)
// out      out_valid / out_stall  out_data  (out_item_t: out_byte, last_of_run)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each accepted byte yields zero to three output bytes, one per cycle while
// out_stall is low; a dropped line ending yields none. Decode and history
// update happen at accept; from an empty queue, out_valid rises once the run
// is written to the queue and then loaded into the output register.
// rst is synchronous: it clears history, queue and output valid, and loads
// the mode registers with their defaults. in_stall rises only while the run
// queue is full; out_stall holds the output register and the serializer.
module line_ending_translator_core import leol_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t          cfg;
  logic          in_accept;
  logic          push, pop;
  run_t          push_run, head;
  queue_status_t q_status;

  // Configuration registers; always ready, writes are registered and take effect in the next cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cr_translation     <= MODE_CR;
      cfg.lf_translation     <= MODE_LF;
      cfg.strip_high_bit     <= 1'b0;
      cfg.expand_blank_lines <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CR_TRANSLATION:     cfg.cr_translation     <= cfg_data[2:0];
        REG_LF_TRANSLATION:     cfg.lf_translation     <= cfg_data[2:0];
        REG_STRIP_HIGH_BIT:     cfg.strip_high_bit     <= cfg_data[0];
        REG_EXPAND_BLANK_LINES: cfg.expand_blank_lines <= cfg_data[0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Hold the input while the run queue has no room
  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  // Front: classify the byte, build its run, advance the history
  leol_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (in_accept),
    .item   (in_data),
    .push   (push),
    .run    (push_run)
  );

  // Short queue of decoded runs between front and back
  leol_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back: serialize each run into the output register, one byte a cycle while out_stall is low
  leol_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_status.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Queue cannot be full and empty at once
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("run queue reports full and empty");

  // An ordinary byte always produces a run
  a_plain_pushes: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_data.in_byte != CHR_CR && in_data.in_byte != CHR_LF) |-> push)
    else $error("ordinary byte accepted without a run");

  // Runs in the queue carry at least one byte
  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_run.count != 2'd0))
    else $error("empty run pushed");

  // Output register is empty right after reset
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: tb/line_ending_translator_checker.sv
module line_ending_translator_checker import leol_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mode registers as the block should hold them
  logic [2:0] cr_mode;
  logic [2:0] lf_mode;
  logic       strip_on;
  logic       expand_on;

  // Emitted-byte history of the current block
  logic [7:0] hist_last;
  logic [7:0] hist_older;
  logic [1:0] hist_count;

  out_item_t expected_bytes[$];
  int        mismatch_count;

  initial begin
    mismatches = 0;
    pending = 0;
    mismatch_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: translator mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void note_history(input logic [7:0] b);
    hist_older = hist_last;
    hist_last = b;
    if (hist_count < 2) hist_count++;
  endfunction

  // Expand one input byte into the bytes the block must emit for it.
  function automatic void translate_byte(input in_item_t item);
    logic [7:0] emitted[3];
    logic [7:0] repl0;
    logic [7:0] repl1;
    logic [2:0] mode;
    logic       hit;
    out_item_t  e;
    int         n;
    int         len;
    n = 0;
    repl0 = '0;
    repl1 = '0;
    if (item.block_start) begin
      hist_last = '0;
      hist_older = '0;
      hist_count = '0;
    end
    if (item.in_byte == CHR_CR || item.in_byte == CHR_LF) begin
      mode = (item.in_byte == CHR_CR) ? cr_mode : lf_mode;
      case (mode)
        MODE_CR: begin
          repl0 = CHR_CR;
          len = 1;
        end
        MODE_LF: begin
          repl0 = CHR_LF;
          len = 1;
        end
        MODE_CR_LF: begin
          repl0 = CHR_CR;
          repl1 = CHR_LF;
          len = 2;
        end
        MODE_LF_CR: begin
          repl0 = CHR_LF;
          repl1 = CHR_CR;
          len = 2;
        end
        default: len = 0;
      endcase
      if (len > 0) begin
        if (expand_on && hist_count >= len) begin
          hit = (len == 1) ? (hist_last == repl0)
                           : (hist_older == repl0 && hist_last == repl1);
          if (hit) begin
            emitted[n] = CHR_SPACE;
            n++;
            note_history(CHR_SPACE);
          end
        end
        emitted[n] = repl0;
        n++;
        note_history(repl0);
        if (len == 2) begin
          emitted[n] = repl1;
          n++;
          note_history(repl1);
        end
      end
    end else begin
      emitted[0] = item.in_byte & (strip_on ? MASK_STRIP : MASK_FULL);
      n = 1;
      note_history(emitted[0]);
    end
    for (int i = 0; i < n; i++) begin
      e.out_byte = emitted[i];
      e.last_of_run = (i == n - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cr_mode = MODE_CR;
      lf_mode = MODE_LF;
      strip_on = 1'b0;
      expand_on = 1'b0;
      hist_last = '0;
      hist_older = '0;
      hist_count = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CR_TRANSLATION:     cr_mode = cfg_data[2:0];
          REG_LF_TRANSLATION:     lf_mode = cfg_data[2:0];
          REG_STRIP_HIGH_BIT:     strip_on = cfg_data[0];
          REG_EXPAND_BLANK_LINES: expand_on = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                    out_data.out_byte, out_data.last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                      out_data.out_byte, want.out_byte));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, wanted %0b (byte %02h)",
                                      out_data.last_of_run, want.last_of_run,
                                      want.out_byte));
        end
      end
      if (in_valid && !in_stall) translate_byte(in_data);
    end
    mismatches <= mismatch_count;
    pending <= expected_bytes.size();
  end

endmodule

FILE: tb/line_ending_translator_core_tb.sv
module line_ending_translator_core_tb import leol_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound: every item at three bytes, each byte held by the longest
  // output stall, plus the longest input gap and the idle waits between phases
  localparam int CYCLE_LIMIT   = 400000;
  // Cycles to let a dropped line ending clear the pipeline before a write
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 41;

  // An index that maps to no register; writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_item_t              out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   mismatches;
  int   pending;
  int   cycle_count;
  // High while the sender runs back to back with no gaps
  logic steady;

  line_ending_translator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_ending_translator_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("line_ending_translator_core test failed");
      $finish;
    end
  end

  // Receiver: long calm stretches, frequent short stalls, a few long ones.
  // Each hold length starts on a fresh edge, so stalls land on every byte
  // of a multi-byte run.
  initial begin
    int r;
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall <= 1'b0;
        hold = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        hold = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        hold = $urandom_range(10, 40);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // Present one byte and hold it until the transaction completes. Valid
  // stays high into the next byte when no gap is drawn, so back-to-back
  // transactions never see valid dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic start);
    in_item_t item;
    int       r;
    int       gap;
    r = $urandom_range(0, 99);
    if (steady || r < 50) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.in_byte = b;
    item.block_start = start;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold the sender until every expected byte is out, then
  // let any dropped line endings drain from the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so consecutive writes never toggle it in one step
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all four registers; unused upper data bits carry random junk
  task automatic set_modes(input logic [2:0] cr, input logic [2:0] lf,
                           input logic strip, input logic expand);
    logic [4:0] pad5;
    logic [6:0] pad7;
    pad5 = $urandom_range(0, 31);
    write_register(REG_CR_TRANSLATION, {pad5, cr});
    pad5 = $urandom_range(0, 31);
    write_register(REG_LF_TRANSLATION, {pad5, lf});
    pad7 = $urandom_range(0, 127);
    write_register(REG_STRIP_HIGH_BIT, {pad7, strip});
    pad7 = $urandom_range(0, 127);
    write_register(REG_EXPAND_BLANK_LINES, {pad7, expand});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [2:0] cr;
    logic [2:0] lf;
    logic [7:0] b;
    logic       start;
    int         r;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    steady = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset modes: CR and LF pass as themselves, high bit kept. The high-bit
    // forms of CR and LF are ordinary bytes.
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHR_CR, 1'b0);
    send_byte(CHR_LF, 1'b0);
    send_byte(CHR_CR ^ 8'h80, 1'b0);
    send_byte(CHR_LF ^ 8'h80, 1'b0);
    drain();

    // Two-byte endings with blank-line spaces and stripping. The first CR of
    // a block has too short a history for a space; the repeat gets one.
    // The stripped high-bit CR must not count as a line ending.
    set_modes(MODE_CR_LF, MODE_LF_CR, 1'b1, 1'b1);
    send_byte(CHR_CR, 1'b1);
    send_byte(CHR_CR, 1'b0);
    send_byte(CHR_LF, 1'b0);
    send_byte(CHR_LF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CHR_CR ^ 8'h80, 1'b0);
    send_byte(CHR_CR, 1'b1);
    drain();

    // One-byte endings: LF becomes CR, so a CR after it repeats the ending
    set_modes(MODE_CR, MODE_CR, 1'b0, 1'b1);
    send_byte(CHR_LF, 1'b1);
    send_byte(CHR_CR, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();

    // Spare mode codes act as drop; a stray write to a missing index first
    write_register(REG_UNUSED, 8'hFF);
    set_modes(3'd5, 3'd7, 1'b0, 1'b1);
    send_byte(CHR_CR, 1'b0);
    send_byte(CHR_LF, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain();

    // Explicit drop on both endings
    set_modes(MODE_DROP, MODE_DROP, 1'b1, 1'b0);
    send_byte(CHR_CR, 1'b0);
    send_byte(CHR_LF, 1'b1);
    send_byte(8'h55, 1'b0);

    // Random phases: mostly line endings so the blank-line logic keeps
    // firing, plus high-bit lookalikes, spaces and arbitrary bytes
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      if (phase == 0) begin
        set_modes(MODE_LF_CR, MODE_LF_CR, 1'b1, 1'b1);
      end else if (phase == 1) begin
        set_modes(MODE_DROP, MODE_CR_LF, 1'b0, 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        cr = (r < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        lf = (r < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        set_modes(cr, lf, 1'($urandom_range(0, 1)), $urandom_range(0, 9) < 7);
      end
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35) b = CHR_CR;
        else if (r < 65) b = CHR_LF;
        else if (r < 70) b = CHR_CR ^ 8'h80;
        else if (r < 75) b = CHR_LF ^ 8'h80;
        else if (r < 80) b = CHR_SPACE;
        else b = 8'($urandom_range(0, 255));
        start = ($urandom_range(0, 7) == 0);
        send_byte(b, start);
      end
      steady = 1'b0;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("line_ending_translator_core test passed");
    end else begin
      $display("line_ending_translator_core test failed");
    end
    $finish;
  end

endmodule
